// File: src/twoi_pkg.sv
// Package for the two-wheel odometry integrator: widths, constants and the
// queue record between front and back. No dependencies.
`timescale 1ns / 1ps
package twoi_pkg;
	localparam int ANGLE_BITS = 16;
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [16:0] SIN_B = 17'd42048;
	localparam logic [16:0] SIN_C = 17'd4640;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [47:0] ACC_MAX = 48'sh7FFFFFFFFFFF;
	localparam logic signed [47:0] ACC_MIN = 48'sh800000000000;

	// One classified sample: count magnitudes, their signs and the angle.
	typedef struct packed {
		logic [31:0] fcnt;
		logic        fneg;
		logic [31:0] scnt;
		logic        sneg;
		logic [ANGLE_BITS-1:0] ang;
	} job_t;
endpackage

// File: src/twoi_front.sv
// Front part: differences the counters against the previous sample and
// queues a job record. Depends on twoi_pkg.
`timescale 1ns / 1ps
module twoi_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] x_counter,
	input  logic [31:0] y_counter,
	input  logic [15:0] heading,
	output logic q_valid,
	input  logic q_ready,
	output twoi_pkg::job_t q_job
);
	logic [31:0] last_x_q, last_y_q, dx, dy;
	twoi_pkg::job_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q, push, pop;
	twoi_pkg::job_t nj;

	assign dx = x_counter - last_x_q;
	assign dy = y_counter - last_y_q;
	always_comb begin
		nj.sneg = dx[31];
		nj.scnt = dx[31] ? (~dx + 32'd1) : dx;
		nj.fneg = dy[31];
		nj.fcnt = dy[31] ? (~dy + 32'd1) : dy;
		nj.ang = twoi_pkg::ANGLE_BITS'(({8'd0, heading} << 8) >> (24 - twoi_pkg::ANGLE_BITS));
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= nj;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				last_x_q <= x_counter;
				last_y_q <= y_counter;
				wp_q <= ~wp_q;
			end
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: src/twoi_back.sv
// Back part: sine/cosine polynomial, four rotated terms and saturating
// accumulators on one sequencer. Depends on twoi_pkg.
`timescale 1ns / 1ps
module twoi_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [23:0] distance_per_count,
	input  logic q_valid,
	output logic q_ready,
	input  twoi_pkg::job_t q_job,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y
);
	localparam int AB = twoi_pkg::ANGLE_BITS;
	localparam logic [4:0] S_IDLE = 5'd0, S_FM = 5'd1, S_SM = 5'd2, S_Z2 = 5'd3,
		S_P1 = 5'd4, S_P2 = 5'd5, S_P3 = 5'd6, S_R1 = 5'd7, S_R2 = 5'd8,
		S_R3 = 5'd9, S_R4 = 5'd10, S_ACC = 5'd11, S_OUT = 5'd12;
	logic [4:0] st_q;
	twoi_pkg::job_t job_q;
	logic [55:0] fmag_q, smag_q;
	logic pass_q;                  // 0 = sine, 1 = cosine
	logic [16:0] z_q, z2_q, r_q, sin_q, cos_q;
	logic sinneg_q, cosneg_q;
	logic [1:0] ti_q;              // rotated term index
	// A rotated term stays below 2^55, so the X/Y increments fit in 57 signed bits.
	logic signed [57:0] dx_q, dy_q;
	logic signed [47:0] ax_q, ay_q;
	logic [55:0] lo_q;

	logic [AB-1:0] a;
	logic [1:0] qd;
	logic [16:0] zf;
	logic [55:0] dm;
	logic [16:0] tm;
	logic dn, tn;
	logic [55:0] pr;
	logic signed [57:0] sx, sy;

	always_comb begin
		a = job_q.ang + (pass_q ? AB'(1) << (AB - 2) : AB'(0));
		qd = a[AB-1:AB-2];
		zf = 17'((({33'd0, a[AB-3:0]}) << 16) >> (AB - 2));
		if (qd[0]) zf = twoi_pkg::ONE_Q16 - zf;
		case (ti_q)
			2'd0: begin dm = smag_q; dn = job_q.sneg; tm = cos_q; tn = cosneg_q; end
			2'd1: begin dm = fmag_q; dn = job_q.fneg; tm = sin_q; tn = sinneg_q; end
			2'd2: begin dm = fmag_q; dn = job_q.fneg; tm = cos_q; tn = cosneg_q; end
			default: begin dm = smag_q; dn = job_q.sneg; tm = sin_q; tn = sinneg_q; end
		endcase
		pr = lo_q + 56'((33'(dm[15:0]) * tm) >> 16);
		sx = 58'(ax_q) + dx_q;
		sy = 58'(ay_q) + dy_q;
	end

	assign q_ready = st_q == S_IDLE;
	assign out_valid = st_q == S_OUT;
	assign pos_x = ax_q;
	assign pos_y = ay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ax_q <= '0;
			ay_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (q_valid) begin
					job_q <= q_job;
					pass_q <= 1'b0;
					st_q <= S_FM;
				end
				S_FM: begin
					fmag_q <= job_q.fcnt * distance_per_count;
					st_q <= S_SM;
				end
				S_SM: begin
					smag_q <= job_q.scnt * distance_per_count;
					st_q <= S_Z2;
				end
				S_Z2: begin
					z_q <= zf;
					z2_q <= 17'((34'(zf) * zf) >> 16);
					st_q <= S_P1;
				end
				S_P1: begin
					r_q <= twoi_pkg::SIN_B - 17'((34'(twoi_pkg::SIN_C) * z2_q) >> 16);
					st_q <= S_P2;
				end
				S_P2: begin
					r_q <= twoi_pkg::SIN_A - 17'((34'(r_q) * z2_q) >> 16);
					st_q <= S_P3;
				end
				S_P3: begin
					if (!pass_q) begin
						sin_q <= (((34'(r_q) * z_q) >> 16) > 34'(twoi_pkg::ONE_Q16)) ?
							twoi_pkg::ONE_Q16 : 17'((34'(r_q) * z_q) >> 16);
						sinneg_q <= qd[1];
						pass_q <= 1'b1;
						st_q <= S_Z2;
					end else begin
						cos_q <= (((34'(r_q) * z_q) >> 16) > 34'(twoi_pkg::ONE_Q16)) ?
							twoi_pkg::ONE_Q16 : 17'((34'(r_q) * z_q) >> 16);
						cosneg_q <= qd[1];
						ti_q <= 2'd0;
						st_q <= S_R1;
					end
				end
				S_R1: begin
					// high part of |d| times |t|
					lo_q <= 56'(dm[55:16]) * tm;
					st_q <= S_R2;
				end
				S_R2: begin
					case (ti_q)
						2'd0: dx_q <= (dn != tn) ? -58'(pr) : 58'(pr);
						2'd1: dx_q <= dx_q - ((dn != tn) ? -58'(pr) : 58'(pr));
						2'd2: dy_q <= (dn != tn) ? -58'(pr) : 58'(pr);
						default: dy_q <= dy_q + ((dn != tn) ? -58'(pr) : 58'(pr));
					endcase
					ti_q <= ti_q + 2'd1;
					st_q <= (ti_q == 2'd3) ? S_ACC : S_R1;
				end
				S_ACC: begin
					ax_q <= (sx > 58'(twoi_pkg::ACC_MAX)) ? twoi_pkg::ACC_MAX :
						(sx < 58'(twoi_pkg::ACC_MIN)) ? twoi_pkg::ACC_MIN : sx[47:0];
					ay_q <= (sy > 58'(twoi_pkg::ACC_MAX)) ? twoi_pkg::ACC_MAX :
						(sy < 58'(twoi_pkg::ACC_MIN)) ? twoi_pkg::ACC_MIN : sy[47:0];
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/two_wheel_odometry_integrator_unit.sv
// Top level of the two-wheel odometry integrator.
// Depends on twoi_pkg, twoi_front and twoi_back.
//
// Use: each input beat on s_axis carries two raw 32-bit wheel counters and a
// heading. The block differences the counters against the previous beat,
// scales them by distance_per_count, rotates them by the heading and adds
// them to saturating 48-bit X/Y position accumulators. Each input beat gives
// one output beat on m_axis with the new position.
// The front part classifies a beat in the cycle it is accepted and writes it
// into a two-entry queue. The back part runs one beat at a time through a
// sequencer that scales both counts, evaluates the sine and then the cosine
// polynomial, forms four rotated terms and updates the accumulators. The
// result is held on m_axis until it is taken, and only then does the back
// part take a new beat; while the receiver stalls, the queue still takes up
// to two more input beats. Reset clears the previous counts, the accumulators
// and distance_per_count to 1.0 mm per count. The user must let cfg_wr_en
// write distance_per_count only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module two_wheel_odometry_integrator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // x_counter[31:0], y_counter[63:32], heading[79:64]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [95:0] m_axis_tdata    // pos_x[47:0], pos_y[95:48]
);
	logic [23:0] dpc_q;
	logic q_valid, q_ready;
	twoi_pkg::job_t q_job;
	logic signed [47:0] pos_x, pos_y;

	// Distance-per-count register, reset to 1.0 in Q8.16.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dpc_q <= 24'd65536;
		else if (cfg_wr_en) dpc_q <= cfg_wr_data;
	end

	twoi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.x_counter(s_axis_tdata[31:0]), .y_counter(s_axis_tdata[63:32]),
		.heading(s_axis_tdata[79:64]),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
	);

	twoi_back u_back (
		.clk(clk), .arst_n(arst_n), .distance_per_count(dpc_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.pos_x(pos_x), .pos_y(pos_y)
	);

	assign m_axis_tdata = {pos_y, pos_x};
endmodule

// File: sim/tb_two_wheel_odometry_integrator_unit.sv
// Self-checking testbench for the two-wheel odometry integrator top level.
// Depends on twoi_pkg and two_wheel_odometry_integrator_unit; needs no files.
// A local dead-reckoning predictor checks every position beat in order.
`timescale 1ns / 1ps
module tb_two_wheel_odometry_integrator_unit;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic signed [47:0] y;
		logic signed [47:0] x;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;   // x_counter[31:0], y_counter[63:32], heading[79:64]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;        // pos_x[47:0], pos_y[95:48]

	two_wheel_odometry_integrator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: mirrors the block's previous counts, accumulators and scale.
	logic [23:0] mm_per_count = 24'd65536;
	logic [31:0] prev_x_count = '0;
	logic [31:0] prev_y_count = '0;
	longint track_x = 0;
	longint track_y = 0;

	logic [79:0] sample_queue[$];
	position_t position_queue[$];
	int fails = 0;
	int idle_cycles = 0;
	bit sample_taken = 1'b0;
	bit calm = 1'b0;

	// Polynomial sine over one quadrant, every product floored by 2^16.
	function automatic logic [16:0] quarter_sine(logic [16:0] z);
		logic [63:0] zz, z2, r;
		zz = 64'(z);
		z2 = (zz * zz) >> 16;
		r = (64'(twoi_pkg::SIN_C) * z2) >> 16;
		r = 64'(twoi_pkg::SIN_B) - r;
		r = (r * z2) >> 16;
		r = 64'(twoi_pkg::SIN_A) - r;
		r = (r * zz) >> 16;
		if (r > 64'(twoi_pkg::ONE_Q16)) r = 64'(twoi_pkg::ONE_Q16);
		return r[16:0];
	endfunction

	// Sine of a binary angle as a magnitude and a sign; odd quadrants mirror the fraction.
	function automatic void angle_sine(input logic [15:0] a, output logic [16:0] mag,
			output bit neg);
		logic [16:0] z;
		z = {1'b0, a[13:0], 2'b00};
		if (a[14]) z = 17'd65536 - z;
		mag = quarter_sine(z);
		neg = a[15];
	endfunction

	// Wrapped count change read as two's complement, scaled to a Q.16 distance.
	function automatic void wheel_travel(input logic [31:0] now, input logic [31:0] was,
			output logic [63:0] mag, output bit neg);
		logic [31:0] diff, cnt;
		diff = now - was;
		neg = diff[31];
		cnt = neg ? (~diff + 32'd1) : diff;
		mag = 64'(cnt) * 64'(mm_per_count);
	endfunction

	function automatic longint rotated_part(logic [63:0] d, bit dneg, logic [16:0] t,
			bit tneg);
		logic [63:0] p;
		p = (d >> 16) * 64'(t) + (((d & 64'hFFFF) * 64'(t)) >> 16);
		return (dneg != tneg) ? -$signed(p) : $signed(p);
	endfunction

	function automatic longint clamp_position(longint v);
		if (v > 64'sd140737488355327) return 64'sd140737488355327;
		if (v < -64'sd140737488355328) return -64'sd140737488355328;
		return v;
	endfunction

	// Advances the dead-reckoning state by one sample and returns the new position.
	function automatic position_t advance_position(logic [79:0] beat);
		logic [63:0] fwd_mag, side_mag;
		bit fwd_neg, side_neg, sin_neg, cos_neg;
		logic [16:0] sin_mag, cos_mag;
		position_t pos;
		wheel_travel(beat[63:32], prev_y_count, fwd_mag, fwd_neg);
		wheel_travel(beat[31:0], prev_x_count, side_mag, side_neg);
		prev_x_count = beat[31:0];
		prev_y_count = beat[63:32];
		angle_sine(beat[79:64], sin_mag, sin_neg);
		angle_sine(beat[79:64] + 16'h4000, cos_mag, cos_neg);
		track_x = clamp_position(track_x + rotated_part(side_mag, side_neg, cos_mag, cos_neg)
			- rotated_part(fwd_mag, fwd_neg, sin_mag, sin_neg));
		track_y = clamp_position(track_y + rotated_part(fwd_mag, fwd_neg, cos_mag, cos_neg)
			+ rotated_part(side_mag, side_neg, sin_mag, sin_neg));
		pos.x = track_x[47:0];
		pos.y = track_y[47:0];
		return pos;
	endfunction

	// Monitor: predicts on every accepted sample beat, checks every position beat,
	// follows register writes and runs the watchdog.
	always @(posedge clk) begin
		position_t want;
		if (arst_n) begin
			sample_taken = s_axis_tvalid && s_axis_tready;
			if (cfg_wr_en) mm_per_count = cfg_wr_data;
			if (sample_taken) position_queue.push_back(advance_position(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (position_queue.size() == 0) begin
					$error("unexpected position beat %h", m_axis_tdata);
					fails++;
				end else begin
					want = position_queue.pop_front();
					if (m_axis_tdata[47:0] !== want.x) begin
						$error("pos_x expected %0d got %0d", want.x,
							$signed(m_axis_tdata[47:0]));
						fails++;
					end
					if (m_axis_tdata[95:48] !== want.y) begin
						$error("pos_y expected %0d got %0d", want.y,
							$signed(m_axis_tdata[95:48]));
						fails++;
					end
				end
			end
			if (sample_taken || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Driver: presents queued samples with random gaps between beats.
	int gap_left = 0;
	always @(negedge clk) begin
		logic next_valid;
		logic [79:0] next_data;
		next_valid = s_axis_tvalid;
		next_data = s_axis_tdata;
		if (arst_n && (!s_axis_tvalid || sample_taken)) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (sample_queue.size() > 0) begin
				next_data = sample_queue.pop_front();
				next_valid = 1'b1;
				gap_left = calm ? 0 : pick_gap();
			end
		end
		s_axis_tvalid <= next_valid;
		s_axis_tdata <= next_data;
	end

	// Receiver: stalls the position stream at random.
	int stall_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = calm ? 0 : pick_gap();
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void queue_sample(logic [31:0] xc, logic [31:0] yc, logic [15:0] hd);
		sample_queue.push_back({hd, yc, xc});
	endfunction

	// Waits until the stream has drained, then lets the back end finish.
	task automatic drain();
		do @(posedge clk);
		while (sample_queue.size() > 0 || s_axis_tvalid || position_queue.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [23:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random walk: mostly small plausible wheel motion, some big jumps and raw noise.
	task automatic queue_walk(int count);
		logic [31:0] wx, wy;
		int roll;
		wx = prev_x_count;
		wy = prev_y_count;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				wx = wx + $urandom_range(0, 4000) - 2000;
				wy = wy + $urandom_range(0, 4000) - 2000;
			end else if (roll < 90) begin
				wx = wx + $urandom;
				wy = wy + $urandom_range(0, 255);
			end else begin
				wx = $urandom;
				wy = $urandom;
			end
			queue_sample(wx, wy, 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset scale of 1.0 mm per count. The first sample
		// is differenced against zero; then the quadrant edges of the heading,
		// the most negative difference and the wrap across zero.
		queue_sample(32'd100, 32'd200, 16'h0000);
		queue_sample(32'd150, 32'd260, 16'h4000);
		queue_sample(32'd150, 32'd360, 16'h8000);
		queue_sample(32'd250, 32'd360, 16'hC000);
		queue_sample(32'd240, 32'd350, 16'hFFFF);
		queue_sample(32'd300, 32'd400, 16'h2000);
		queue_sample(32'hFFFF_FFF0, 32'h0000_0010, 16'h3FFF);
		queue_sample(32'h0000_0010, 32'hFFFF_FFF0, 16'h4001);
		queue_sample(32'h8000_0010, 32'h7FFF_FFF0, 16'h6000);
		queue_sample(32'h0000_000F, 32'hFFFF_FFFF, 16'hA000);
		queue_sample(32'h0000_000F, 32'hFFFF_FFFF, 16'hE000);
		drain();

		// Full scale with the largest jumps drives both accumulators into saturation.
		write_scale(24'hFFFFFF);
		queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000);
		queue_sample(32'hFFFF_FFFE, 32'hFFFF_FFFE, 16'h2000);
		queue_sample(32'h7FFF_FFFE, 32'h7FFF_FFFE, 16'h2000);
		queue_sample(32'hFFFF_FFFE, 32'hFFFF_FFFE, 16'hA000);
		queue_sample(32'h7FFF_FFFE, 32'h7FFF_FFFE, 16'hA000);
		queue_sample(32'hFFFF_FFFE, 32'hFFFF_FFFE, 16'hA000);
		queue_sample(32'h0000_0000, 32'h0000_0000, 16'h5555);
		drain();

		// Zero scale: any wheel motion leaves the position where it is.
		write_scale(24'd0);
		queue_walk(20);
		drain();

		// Random part with several scales, one phase without any idling.
		write_scale(24'd65536);
		queue_walk(250);
		drain();
		calm = 1'b1;
		write_scale(24'h000001);
		queue_walk(150);
		drain();
		calm = 1'b0;
		write_scale(24'($urandom_range(0, 24'hFFFFFF)));
		queue_walk(200);
		drain();
		write_scale(24'hFFFFFF);
		queue_walk(200);
		drain();

		if (fails == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule
